[rtl/jdc_pkg.sv]
// ----------------------------------------------------------------------------
// jdc_pkg
// Constants and payload types shared by the day-number-to-date pipeline.
// ----------------------------------------------------------------------------
package jdc_pkg;

  // Calendar period lengths in days
  localparam int CYCLE_DAYS = 146097;  // 400 years
  localparam int CENT_DAYS  = 36524;
  localparam int QUAD_DAYS  = 1461;
  localparam int YEAR_DAYS  = 365;

  // Biased day count: jd + 32044 + CYCLE_BIAS * 146097, never negative
  localparam int  CYCLE_BIAS = 14700;
  localparam longint DAY_BIAS = 64'd32044 + 64'(CYCLE_BIAS) * 64'(CYCLE_DAYS);

  // floor(2^43 / 146097), used on day_count >> 11 with the product shifted right by 32
  localparam int CYCLE_RECIP = 60207211;
  // ceil(2^26 / 1461), exact for values up to one century
  localparam int QUAD_RECIP  = 45934;
  // month index = (day_in_year * 5 + 308) / 153, folded to one product >> 18
  localparam int MON_MULT    = 8570;    // 5 * 1714
  localparam int MON_ADD     = 527912;  // 308 * 1714

  // Year of cycle zero: -CYCLE_BIAS * 400 - 4800
  localparam int YEAR_BIAS   = -5884800;

  typedef struct packed {
    logic [14:0] cyc_idx;       // biased 400-year cycle index
    logic [17:0] day_in_cycle;
  } cyc_t;

  typedef struct packed {
    logic [23:0] year_base;     // two's complement, March-based year
    logic [8:0]  day_in_year;   // 0 is 1 March
  } yday_t;

  // Days from 1 March to the first of the month, month index 2 is March
  function automatic logic [8:0] first_day(input logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd2:    d = 9'd0;
      4'd3:    d = 9'd31;
      4'd4:    d = 9'd61;
      4'd5:    d = 9'd92;
      4'd6:    d = 9'd122;
      4'd7:    d = 9'd153;
      4'd8:    d = 9'd184;
      4'd9:    d = 9'd214;
      4'd10:   d = 9'd245;
      4'd11:   d = 9'd275;
      4'd12:   d = 9'd306;
      4'd13:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

[rtl/jdc_cycle.sv]
// ----------------------------------------------------------------------------
// jdc_cycle
// Floor division of the shifted day number into 400-year cycles: reciprocal
// estimate, back-multiply, single correction step.
// ----------------------------------------------------------------------------
module jdc_cycle
  import jdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] julian_day,
  output logic               out_valid,
  input  logic               out_ready,
  output cyc_t               out_data
);

  logic        v1, v2, v3;
  logic        rdy1, rdy2, rdy3;
  logic [32:0] count1;
  logic [14:0] quot1, quot2, quot3;
  logic [18:0] rem2;
  logic [17:0] rem3;

  logic [33:0] count_wide;
  logic [32:0] count_next;
  logic [47:0] est_prod;
  logic [32:0] back_prod;
  logic [32:0] rem_full;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    count_wide = {{2{julian_day[31]}}, julian_day} + 34'(DAY_BIAS);
    count_next = count_wide[32:0];
    est_prod   = 48'(count_next[32:11]) * 48'(CYCLE_RECIP);
    back_prod  = 33'(quot1) * 33'(CYCLE_DAYS);
    rem_full   = count1 - back_prod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // estimate is exact or one low
  always_ff @(posedge clk) begin
    if (rdy1) begin
      count1 <= count_next;
      quot1  <= est_prod[46:32];
    end
    if (rdy2) begin
      quot2 <= quot1;
      rem2  <= rem_full[18:0];
    end
    if (rdy3) begin
      if (rem2 >= 19'(CYCLE_DAYS)) begin
        quot3 <= quot2 + 15'd1;
        rem3  <= 18'(rem2 - 19'(CYCLE_DAYS));
      end else begin
        quot3 <= quot2;
        rem3  <= rem2[17:0];
      end
    end
  end

  assign out_valid             = v3;
  assign out_data.cyc_idx      = quot3;
  assign out_data.day_in_cycle = rem3;

endmodule

[rtl/jdc_split.sv]
// ----------------------------------------------------------------------------
// jdc_split
// Splits the day within a 400-year cycle into centuries, four-year groups
// and years, and builds the March-based year.
// ----------------------------------------------------------------------------
module jdc_split
  import jdc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  cyc_t  in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output yday_t out_data
);

  logic        v4, v5, v6, v7;
  logic        rdy4, rdy5, rdy6, rdy7;
  logic [23:0] yb4, yb5, yb6, yb7;
  logic [1:0]  cent4;
  logic [15:0] in_cent4, in_cent5;
  logic [4:0]  quad5;
  logic [10:0] in_quad6;
  logic [8:0]  in_year7;

  logic [1:0]  cent_next;
  logic [17:0] cent_off;
  logic [23:0] cyc_years;
  logic [23:0] cent_years;
  logic [31:0] quad_prod;
  logic [1:0]  yr_next;
  logic [10:0] yr_off;

  assign rdy7     = !v7 || out_ready;
  assign rdy6     = !v6 || rdy7;
  assign rdy5     = !v5 || rdy6;
  assign rdy4     = !v4 || rdy5;
  assign in_ready = rdy4;

  // the last, longer century lands on index 3 by itself
  always_comb begin
    cent_next = 2'(in_data.day_in_cycle >= 18'(CENT_DAYS))
              + 2'(in_data.day_in_cycle >= 18'(2 * CENT_DAYS))
              + 2'(in_data.day_in_cycle >= 18'(3 * CENT_DAYS));
    case (cent_next)
      2'd0:    cent_off = 18'd0;
      2'd1:    cent_off = 18'(CENT_DAYS);
      2'd2:    cent_off = 18'(2 * CENT_DAYS);
      2'd3:    cent_off = 18'(3 * CENT_DAYS);
      default: cent_off = 18'd0;
    endcase
    cyc_years = 24'(in_data.cyc_idx) * 24'd400 + 24'(YEAR_BIAS);

    case (cent4)
      2'd0:    cent_years = 24'd0;
      2'd1:    cent_years = 24'd100;
      2'd2:    cent_years = 24'd200;
      2'd3:    cent_years = 24'd300;
      default: cent_years = 24'd0;
    endcase
    quad_prod = 32'(in_cent4) * 32'(QUAD_RECIP);

    yr_next = 2'(in_quad6 >= 11'(YEAR_DAYS))
            + 2'(in_quad6 >= 11'(2 * YEAR_DAYS))
            + 2'(in_quad6 >= 11'(3 * YEAR_DAYS));
    case (yr_next)
      2'd0:    yr_off = 11'd0;
      2'd1:    yr_off = 11'(YEAR_DAYS);
      2'd2:    yr_off = 11'(2 * YEAR_DAYS);
      2'd3:    yr_off = 11'(3 * YEAR_DAYS);
      default: yr_off = 11'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (rdy4) v4 <= in_valid;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
      if (rdy7) v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      yb4      <= cyc_years;
      cent4    <= cent_next;
      in_cent4 <= 16'(in_data.day_in_cycle - cent_off);
    end
    if (rdy5) begin
      yb5      <= yb4 + cent_years;
      quad5    <= quad_prod[30:26];
      in_cent5 <= in_cent4;
    end
    if (rdy6) begin
      yb6      <= yb5 + 24'({quad5, 2'b00});
      in_quad6 <= 11'(in_cent5 - 16'(16'(quad5) * 16'(QUAD_DAYS)));
    end
    if (rdy7) begin
      yb7      <= yb6 + 24'(yr_next);
      in_year7 <= 9'(in_quad6 - yr_off);
    end
  end

  assign out_valid            = v7;
  assign out_data.year_base   = yb7;
  assign out_data.day_in_year = in_year7;

endmodule

[rtl/jdc_month.sv]
// ----------------------------------------------------------------------------
// jdc_month
// Month and day from the March-based day of year; rolls January and
// February into the following year. Holds the result register.
// ----------------------------------------------------------------------------
module jdc_month
  import jdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  yday_t       in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] year_number,
  output logic [3:0]  month_number,
  output logic [4:0]  day_number
);

  logic        v8, v9;
  logic        rdy8, rdy9;
  logic [3:0]  mon8;
  logic [8:0]  iy8;
  logic [23:0] yb8;

  logic [21:0] mon_prod;
  logic        next_year;

  assign rdy9     = !v9 || out_ready;
  assign rdy8     = !v8 || rdy9;
  assign in_ready = rdy8;

  always_comb begin
    mon_prod  = 22'(in_data.day_in_year) * 22'(MON_MULT) + 22'(MON_ADD);
    next_year = (mon8 >= 4'd12);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else begin
      if (rdy8) v8 <= in_valid;
      if (rdy9) v9 <= v8;
    end
  end

  // month index 2 is March, 13 is February
  always_ff @(posedge clk) begin
    if (rdy8) begin
      mon8 <= mon_prod[21:18];
      iy8  <= in_data.day_in_year;
      yb8  <= in_data.year_base;
    end
    if (rdy9) begin
      year_number  <= yb8 + 24'(next_year);
      month_number <= next_year ? mon8 - 4'd11 : mon8 + 4'd1;
      day_number   <= 5'(iy8 - first_day(mon8) + 9'd1);
    end
  end

  assign out_valid = v9;

endmodule

[rtl/civil_date_from_julian_day.sv]
// ----------------------------------------------------------------------------
// civil_date_from_julian_day
// Julian day number to proleptic Gregorian year, month and day.
// ----------------------------------------------------------------------------
// Fully pipelined, one beat in and one beat out per cycle while the sink is
// ready, through nine register stages (the 400-year division takes three,
// the century/four-year/year split four, the month and day two).
// Backpressure collapses bubbles stage by stage, so the input stays ready
// while the result register holds a beat, as long as some stage is empty.
// Any 32-bit day number is legal; negatives use floor division. Years are
// astronomical (year 0 is 1 BC). Reset clears only the valid flags.
module civil_date_from_julian_day
  import jdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] julian_day (signed)
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [23:0] year_number (signed),
                                      // [27:24] month_number, [32:28] day_number
);

  logic        cyc_valid, cyc_ready;
  cyc_t        cyc_data;
  logic        yd_valid, yd_ready;
  yday_t       yd_data;
  logic [23:0] year_number;
  logic [3:0]  month_number;
  logic [4:0]  day_number;

  jdc_cycle u_cycle (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .julian_day (signed'(s_axis_tdata)),
    .out_valid  (cyc_valid),
    .out_ready  (cyc_ready),
    .out_data   (cyc_data)
  );

  jdc_split u_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cyc_valid),
    .in_ready  (cyc_ready),
    .in_data   (cyc_data),
    .out_valid (yd_valid),
    .out_ready (yd_ready),
    .out_data  (yd_data)
  );

  jdc_month u_month (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (yd_valid),
    .in_ready     (yd_ready),
    .in_data      (yd_data),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .year_number  (year_number),
    .month_number (month_number),
    .day_number   (day_number)
  );

  assign m_axis_tdata = {7'd0, day_number, month_number, year_number};

  // every stage can advance when the sink is ready, so the input is ready too
  a_ready_chain : assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input not ready while output drains");

  a_month_range : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[27:24] >= 4'd1 && m_axis_tdata[27:24] <= 4'd12))
    else $error("month out of range");

  a_day_range : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[32:28] >= 5'd1 && m_axis_tdata[32:28] <= 5'd31))
    else $error("day out of range");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid straight after reset");

endmodule
